[rtl/cubic_hermite_varispeed_resampler_macros.svh]
// Assertion macros used by the resampler top level.
`ifndef CUBIC_HERMITE_VARISPEED_RESAMPLER_MACROS_SVH
`define CUBIC_HERMITE_VARISPEED_RESAMPLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHVR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/chvr_pkg.sv]
// Types and constants of the cubic Hermite resampler.
`timescale 1ns / 1ps
`default_nettype none

package chvr_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned OFFS_W   = 19;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned CNT_W    = 6;

  localparam logic [OFFS_W-1:0] ONE_Q16      = 19'd65536;
  localparam logic [OFFS_W-1:0] OFFSET_RESET = 19'd196608;
  localparam logic [OFFS_W-1:0] RATE_MIN     = 19'd1024;
  localparam logic [OFFS_W-1:0] RATE_MAX     = 19'd262144;
  localparam logic [OFFS_W-1:0] RATE_RESET   = 19'd65536;
  localparam logic [CNT_W-1:0]  LAST_SLOT    = 6'd63;

  // lane pipeline depth, frac/window in to result out
  localparam logic [2:0] LANE_LAT = 3'd6;

  // register index of the rate register
  localparam logic REG_RATE = 1'b0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [3:0] window_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic last;
  } load_t;

endpackage

`default_nettype wire

[rtl/chvr_if.sv]
// Valid/ready stream interfaces for resampler input frames and results.
`timescale 1ns / 1ps
`default_nettype none

interface chvr_in_if;
  logic               valid;
  logic               ready;
  chvr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface chvr_out_if;
  logic                valid;
  logic                ready;
  chvr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/chvr_lane.sv]
// One channel of Catmull-Rom interpolation, six register stages deep.
`timescale 1ns / 1ps
`default_nettype none

module chvr_lane (
  input  logic              clk_i,
  input  chvr_pkg::window_t win_i,
  input  logic [15:0]       frac_i,
  output chvr_pkg::sample_t res_o
);

  logic signed [23:0] y0, y1, y2, y3;
  logic signed [24:0] c1;
  logic signed [28:0] c2, c3;
  logic signed [16:0] ts;

  logic signed [45:0] p1_q, a_q;
  logic signed [46:0] mh_q;
  logic        [31:0] ml_q;
  logic signed [47:0] b_q;
  logic signed [48:0] nh_q;
  logic        [31:0] nl_q;
  logic signed [23:0] res_q;

  logic        [32:0] rnd1_sum;
  logic        [16:0] rnd1;
  logic        [33:0] rnd2_sum;
  logic        [17:0] rnd2;
  logic signed [49:0] s_sum;
  logic signed [33:0] r_sum;

  // window is held steady for the whole run, so coefficients are read live
  assign y0 = $signed(win_i[0]);
  assign y1 = $signed(win_i[1]);
  assign y2 = $signed(win_i[2]);
  assign y3 = $signed(win_i[3]);
  assign ts = $signed({1'b0, frac_i});

  assign c1 = 25'(y2) - 25'(y0);
  assign c2 = 29'(y0) * 29'sd2 - 29'(y1) * 29'sd5 + 29'(y2) * 29'sd4 - 29'(y3);
  assign c3 = 29'(y3) - 29'(y0) + (29'(y1) - 29'(y2)) * 29'sd3;

  // a*t split as a_hi*t*2^16 + a_lo*t keeps every product at most 32x17
  assign rnd1_sum = 33'(ml_q) + 33'h0_0000_8000;
  assign rnd1     = rnd1_sum[32:16];
  assign rnd2_sum = 34'(nl_q) + 34'h1_0000_0000;
  assign rnd2     = rnd2_sum[33:16];
  assign s_sum    = 50'(nh_q) + 50'($signed({1'b0, rnd2}));
  assign r_sum    = 34'(y1) + 34'($signed(s_sum[49:17]));

  always_ff @(posedge clk_i) begin
    p1_q <= c3 * ts;
    a_q  <= p1_q + (46'(c2) <<< 16);
    mh_q <= $signed(a_q[45:16]) * ts;
    ml_q <= a_q[15:0] * frac_i;
    b_q  <= 48'(mh_q) + 48'($signed({1'b0, rnd1})) + (48'(c1) <<< 16);
    nh_q <= $signed(b_q[47:16]) * ts;
    nl_q <= b_q[15:0] * frac_i;
    if (r_sum > 34'sd8388607) begin
      res_q <= 24'sh7FFFFF;
    end else if (r_sum < -34'sd8388608) begin
      res_q <= 24'sh800000;
    end else begin
      res_q <= r_sum[23:0];
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[rtl/chvr_merge.sv]
// Merges lane results into one output item and holds it until taken.
`timescale 1ns / 1ps
`default_nettype none

module chvr_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  chvr_pkg::load_t   ctl_i,
  input  chvr_pkg::sample_t res_i [2],
  output logic              can_load_o,
  chvr_out_if.source        out_o
);

  logic                valid_q;
  chvr_pkg::out_item_t data_q;

  assign can_load_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      data_q.out_left    <= res_i[0];
      data_q.out_right   <= res_i[1];
      data_q.last_of_run <= ctl_i.last;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

endmodule

`default_nettype wire

[rtl/cubic_hermite_varispeed_resampler.sv]
// Top level of the varispeed stereo cubic Hermite resampler.
//
//  channel   dir  handshake            payload
//  in_i      in   valid/ready          sample_left, sample_right
//  out_o     out  valid/ready          out_left, out_right, last_of_run
//  apb       in   psel/penable/pready  rate at byte address 0
//
// Each output frame presents the fraction to the lanes and waits for the lane
// multiplier pipeline to settle; an input frame yields 0..64 outputs.
// One input frame is taken only when the previous run is fully computed.
// A full output register stalls the next result load; inputs may still enter
// once the last result of a run is loaded. Reset clears windows and sets
// offset 3.0 and rate 1.0.
`timescale 1ns / 1ps
`default_nettype none

`include "cubic_hermite_varispeed_resampler_macros.svh"

module cubic_hermite_varispeed_resampler #(
  parameter int CHANNELS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chvr_in_if.sink     in_i,
  chvr_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic                                state_q, state_d;
  logic [chvr_pkg::OFFS_W-1:0]         rate_q;
  logic [chvr_pkg::OFFS_W-1:0]         off_q, off_d;
  logic [2:0]                          cnt_q, cnt_d;
  logic [chvr_pkg::CNT_W-1:0]          nout_q, nout_d;
  chvr_pkg::window_t                   win_q [2];
  chvr_pkg::sample_t [1:0]             in_smp;
  chvr_pkg::sample_t                   lane_res [2];

  logic [chvr_pkg::OFFS_W-1:0]         step;
  logic [chvr_pkg::OFFS_W-1:0]         off_sh;
  logic [chvr_pkg::OFFS_W:0]           off_sum;
  logic [chvr_pkg::OFFS_W-1:0]         off_next;
  logic                                in_fire;
  logic                                cfg_wr;
  logic                                can_load;
  chvr_pkg::load_t                     ctl;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == chvr_pkg::REG_RATE) ? 32'(rate_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= chvr_pkg::RATE_RESET;
    end else if (cfg_wr && paddr[2] == chvr_pkg::REG_RATE) begin
      rate_q <= pwdata[chvr_pkg::OFFS_W-1:0];
    end
  end

  assign step = (rate_q < chvr_pkg::RATE_MIN) ? chvr_pkg::RATE_MIN :
                (rate_q > chvr_pkg::RATE_MAX) ? chvr_pkg::RATE_MAX : rate_q;

  // input side
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_smp[0]  = in_i.data.sample_left;
  assign in_smp[1]  = in_i.data.sample_right;

  // offset drops one frame on each input, saturating at zero
  assign off_sh   = (off_q >= chvr_pkg::ONE_Q16) ? off_q - chvr_pkg::ONE_Q16 : '0;
  assign off_sum  = 20'(off_q) + 20'(step);
  assign off_next = off_sum[chvr_pkg::OFFS_W-1:0];

  always_comb begin
    state_d   = state_q;
    off_d     = off_q;
    cnt_d     = cnt_q;
    nout_d    = nout_q;
    ctl.load  = 1'b0;
    ctl.last  = (off_next >= chvr_pkg::ONE_Q16) || (nout_q == chvr_pkg::LAST_SLOT);
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          off_d  = off_sh;
          cnt_d  = '0;
          nout_d = '0;
          if (off_sh < chvr_pkg::ONE_Q16) begin
            state_d = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (cnt_q != chvr_pkg::LANE_LAT) begin
          cnt_d = cnt_q + 3'd1;
        end else if (can_load) begin
          ctl.load = 1'b1;
          off_d    = off_next;
          cnt_d    = '0;
          nout_d   = nout_q + 6'd1;
          if (ctl.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      off_q   <= chvr_pkg::OFFSET_RESET;
      cnt_q   <= '0;
      nout_q  <= '0;
    end else begin
      state_q <= state_d;
      off_q   <= off_d;
      cnt_q   <= cnt_d;
      nout_q  <= nout_d;
    end
  end

  // per-channel windows and lanes; an absent channel stays zero
  for (genvar ch = 0; ch < 2; ch++) begin : g_ch
    if (ch < CHANNELS) begin : g_on
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          win_q[ch] <= '0;
        end else if (in_fire) begin
          win_q[ch] <= {in_smp[ch], win_q[ch][3:1]};
        end
      end

      chvr_lane u_lane (
        .clk_i  (clk_i),
        .win_i  (win_q[ch]),
        .frac_i (off_q[chvr_pkg::FRAC_W-1:0]),
        .res_o  (lane_res[ch])
      );
    end else begin : g_off
      assign win_q[ch]    = '0;
      assign lane_res[ch] = '0;
    end
  end

  chvr_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .res_i      (lane_res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

  `CHVR_ASSERT_SAME(a_calc_frac, clk_i, rst_ni, state_q == ST_CALC,
    off_q < chvr_pkg::ONE_Q16, "read offset not below one during a run")
  `CHVR_ASSERT_SAME(a_load_time, clk_i, rst_ni, ctl.load,
    cnt_q == chvr_pkg::LANE_LAT, "result loaded before lanes settled")
  `CHVR_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, ctl.load && ctl.last,
    state_q == ST_IDLE && out_o.valid, "run did not end on last result")
  `CHVR_ASSERT_NEXT(a_no_output, clk_i, rst_ni, in_fire && off_sh >= chvr_pkg::ONE_Q16,
    state_q == ST_IDLE, "run started with offset at or above one")

endmodule

`default_nettype wire

[bench/cubic_hermite_varispeed_resampler_test.sv]
// Self-checking bench for the varispeed cubic Hermite resampler: streams, APB rate, scoreboard.
`timescale 1ns / 1ps

class hermite_scoreboard;
  localparam int RUN_LIMIT = int'(chvr_pkg::LAST_SLOT) + 1;

  chvr_pkg::sample_t        win_l [4];
  chvr_pkg::sample_t        win_r [4];
  logic [18:0]              offset;
  logic [18:0]              rate_reg;
  int                       channels;
  int unsigned              bad_count;
  chvr_pkg::out_item_t      due_outputs [$];

  function new(int chans);
    channels  = chans;
    offset    = chvr_pkg::OFFSET_RESET;
    rate_reg  = chvr_pkg::RATE_RESET;
    bad_count = 0;
    for (int i = 0; i < 4; i++) begin
      win_l[i] = '0;
      win_r[i] = '0;
    end
  endfunction

  function int pending();
    return due_outputs.size();
  endfunction

  function void take_config(int unsigned index, logic [31:0] value);
    if (index == int'(chvr_pkg::REG_RATE)) rate_reg = value[18:0];
  endfunction

  // Catmull-Rom point between y1 and y2, exact integer terms, floor shifts
  static function chvr_pkg::sample_t hermite_point(longint y0, longint y1, longint y2,
                                                   longint y3, logic [15:0] t);
    longint ti, c1, c2, c3, a, b, r;
    ti = longint'({48'd0, t});
    c1 = y2 - y0;
    c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
    c3 = y3 - y0 + 3 * (y1 - y2);
    a  = c3 * ti + c2 * 64'sd65536;
    b  = ((a * ti + 64'sd32768) >>> 16) + c1 * 64'sd65536;
    r  = y1 + ((b * ti + (64'sd1 <<< 32)) >>> 33);
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return r[23:0];
  endfunction

  function void take_frame(chvr_pkg::in_item_t it);
    logic [18:0]         step;
    chvr_pkg::out_item_t e;
    int                  n;
    step = rate_reg;
    if (step < chvr_pkg::RATE_MIN) step = chvr_pkg::RATE_MIN;
    if (step > chvr_pkg::RATE_MAX) step = chvr_pkg::RATE_MAX;
    for (int i = 0; i < 3; i++) begin
      win_l[i] = win_l[i+1];
      if (channels >= 2) win_r[i] = win_r[i+1];
    end
    win_l[3] = it.sample_left;
    if (channels >= 2) win_r[3] = it.sample_right;
    // offset saturates at zero on the shift
    if (offset >= chvr_pkg::ONE_Q16) offset = offset - chvr_pkg::ONE_Q16;
    else offset = '0;
    n = 0;
    while (offset < chvr_pkg::ONE_Q16 && n < RUN_LIMIT) begin
      e.out_left  = hermite_point(win_l[0], win_l[1], win_l[2], win_l[3], offset[15:0]);
      e.out_right = (channels >= 2) ?
                    hermite_point(win_r[0], win_r[1], win_r[2], win_r[3], offset[15:0]) : '0;
      offset = offset + step;
      n++;
      e.last_of_run = !(offset < chvr_pkg::ONE_Q16 && n < RUN_LIMIT);
      due_outputs.push_back(e);
    end
  endfunction

  function void check_output(chvr_pkg::out_item_t got);
    chvr_pkg::out_item_t want;
    if (due_outputs.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("unexpected output item: L=%0d R=%0d last=%0b",
                 got.out_left, got.out_right, got.last_of_run);
      return;
    end
    want = due_outputs.pop_front();
    if (got.out_left !== want.out_left || got.out_right !== want.out_right ||
        got.last_of_run !== want.last_of_run) begin
      bad_count++;
      if (bad_count <= 10)
        $display("mismatch: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                 want.out_left, want.out_right, want.last_of_run,
                 got.out_left, got.out_right, got.last_of_run);
    end
  endfunction
endclass

module cubic_hermite_varispeed_resampler_test;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  localparam int         NUM_CHANNELS  = 2;
  localparam int         RUN_LIMIT     = int'(chvr_pkg::LAST_SLOT) + 1;
  localparam int         SETTLE_CYCLES = (int'(chvr_pkg::LANE_LAT) + 1) * RUN_LIMIT + 16;
  localparam int         DRAIN_LIMIT   = 200000;
  localparam int         RAND_PHASES   = 12;
  localparam int         PHASE_ITEMS   = 22;
  localparam logic [2:0] RATE_ADDR     = 3'(4 * int'(chvr_pkg::REG_RATE));
  localparam logic [2:0] UNUSED_ADDR   = 3'd4;
  localparam chvr_pkg::sample_t S_MAX  = 24'sh7FFFFF;
  localparam chvr_pkg::sample_t S_MIN  = 24'sh800000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;

  int tx_pct = 0;
  int rx_pct = 0;

  hermite_scoreboard    sb;
  chvr_pkg::in_item_t   walk_frame;

  chvr_pkg::sample_t corner_vals [8] = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF,
                                         24'sh000001, 24'sh555555, 24'shAAAAAA, 24'sh123456};

  chvr_in_if  in_if ();
  chvr_out_if out_if ();

  cubic_hermite_varispeed_resampler #(
    .CHANNELS(NUM_CHANNELS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99, 0) >= rx_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (in_if.valid && in_if.ready) sb.take_frame(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_output(out_if.data);
    end
  end

  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic chvr_pkg::sample_t walk_sample(chvr_pkg::sample_t prev);
    int span;
    int v;
    span = 1 << $urandom_range(20, 6);
    v = int'(prev) + int'($urandom_range(2 * span, 0)) - span;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic chvr_pkg::in_item_t make_frame(chvr_pkg::in_item_t prev);
    chvr_pkg::in_item_t f;
    int                 pick;
    pick = $urandom_range(99, 0);
    if (pick < 55) begin
      f.sample_left  = walk_sample(prev.sample_left);
      f.sample_right = walk_sample(prev.sample_right);
    end else if (pick < 85) begin
      f.sample_left  = 24'($urandom());
      f.sample_right = 24'($urandom());
    end else begin
      f.sample_left  = corner_vals[$urandom_range(4, 0)];
      f.sample_right = corner_vals[$urandom_range(4, 0)];
    end
    return f;
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(9, 0))
      0:       return 32'(chvr_pkg::RATE_MIN);
      1:       return 32'(chvr_pkg::RATE_MAX);
      2:       return $urandom_range(1023, 0);
      // above the clamp, with random upper pwdata bits as well
      3:       return $urandom_range(524287, 262145) | ($urandom() & 32'hFFF80000);
      default: return $urandom_range(200000, 4096);
    endcase
  endfunction

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin tx_pct = 0;  rx_pct = 0;  end
      IDLE_SENDER:   begin tx_pct = 81; rx_pct = 0;  end
      IDLE_RECEIVER: begin tx_pct = 0;  rx_pct = 81; end
      default:       begin tx_pct = 35; rx_pct = 35; end
    endcase
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.take_config(int'(addr) >> 2, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // block idle: no results due, plus time for a run that yields none
  task automatic quiesce();
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_frame(chvr_pkg::in_item_t f);
    if (tx_pct != 0 && $urandom_range(99, 0) < tx_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < tx_pct);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= f;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // full-scale square wave: overshoot between frames hits saturation
  task automatic send_alternating(int count);
    chvr_pkg::in_item_t f;
    for (int i = 0; i < count; i++) begin
      f.sample_left  = (i % 2 == 1) ? S_MIN : S_MAX;
      f.sample_right = (i % 2 == 1) ? S_MAX : S_MIN;
      send_frame(f);
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic send_random(int count, bit pause_mid);
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) begin
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
      walk_frame = make_frame(walk_frame);
      send_frame(walk_frame);
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    chvr_pkg::in_item_t f;
    int                 waited;
    sb = new(NUM_CHANNELS);
    walk_frame   = '0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset rate, start of stream from a zero window
    set_idle(IDLE_NONE);
    for (int i = 0; i < 10; i++) begin
      f.sample_left  = corner_vals[i % 8];
      f.sample_right = corner_vals[7 - (i % 8)];
      send_frame(f);
    end
    in_if.valid <= 1'b0;

    quiesce();
    write_reg(RATE_ADDR, 32'(chvr_pkg::RATE_MIN));
    send_alternating(5);

    quiesce();
    write_reg(RATE_ADDR, 32'(chvr_pkg::RATE_MAX));
    // write to a non-existent register must not touch the rate
    write_reg(UNUSED_ADDR, 32'(chvr_pkg::RATE_MIN));
    send_alternating(4);

    // rate below and above the legal range, clamped on use
    quiesce();
    write_reg(RATE_ADDR, 32'd0);
    send_alternating(2);
    quiesce();
    write_reg(RATE_ADDR, 32'h7FFFF);
    send_alternating(2);

    for (int p = 0; p < RAND_PHASES; p++) begin
      quiesce();
      write_reg(RATE_ADDR, pick_rate());
      set_idle(idle_mode_e'(p % 4));
      send_random(PHASE_ITEMS, p % 2 == 1);
    end

    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (sb.pending() != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (sb.bad_count == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/chvr_pkg.sv
rtl/chvr_if.sv
rtl/chvr_lane.sv
rtl/chvr_merge.sv
rtl/cubic_hermite_varispeed_resampler.sv
bench/cubic_hermite_varispeed_resampler_test.sv
